FILE: hw/rtl/otsu_pkg.sv
`default_nettype none
package otsu_pkg;

  localparam int unsigned MAX_PIXELS = 4194304;
  localparam int unsigned BINS       = 256;
  localparam int unsigned BW         = 8;                       // bin address
  localparam int unsigned NW         = $clog2(MAX_PIXELS + 1);  // count width
  localparam int unsigned SW         = NW + BW;                 // gray sum width
  localparam int unsigned DW         = NW + SW;                 // |S*w - N*m|
  localparam int unsigned QW         = 2 * NW;                  // w*(N-w)
  localparam int unsigned D2W        = 2 * DW;                  // d^2
  localparam int unsigned PW         = D2W + QW;                // d^2 * q
  localparam int unsigned GW         = NW + 10;                 // 1000 * count

  localparam logic [NW-1:0] MAX_CNT  = NW'(MAX_PIXELS);
  localparam logic [GW-1:0] GUARD_K  = GW'(1000);
  localparam logic [BW-1:0] K_FIRST  = BW'(1);
  localparam logic [BW-1:0] K_LAST   = BW'(254);
  localparam logic [BW-1:0] K_END    = BW'(255);

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_INC,
    ST_RD,
    ST_ACC,
    ST_EVAL,
    ST_SW,
    ST_NM,
    ST_Q,
    ST_DD,
    ST_L,
    ST_R,
    ST_OUT
  } state_t;

  function automatic logic [BW-1:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    logic [12:0] sum;
    sum = 13'(11) * 13'(r) + 13'(16) * 13'(g) + 13'(5) * 13'(b);
    return sum[12:5];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/otsu_ram.sv
`default_nettype none
module otsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/otsu_threshold_select_core.sv
`default_nettype none
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// in       | start & !busy        | in_pixel_red/green/blue, in_frame_last
// out      | out_valid (1 cycle)  | out_threshold, out_split_found, out_overflow
//
// A pixel is one histogram RAM read, then the incremented write-back.
// A dropped pixel (histogram full) is not counted and sets the overflow flag.
// The frame-end scan visits 256 bins, each through the RD, ACC and EVAL states;
// each qualifying split adds the shift-add multiplier passes (one bit per cycle).
// After reset a clearing pass zeroes all 256 bins with busy held high;
// later bins are zeroed as the scan reads them. The receiver cannot stall results.
module otsu_threshold_select_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_pixel_red,
  input  wire logic [7:0] in_pixel_green,
  input  wire logic [7:0] in_pixel_blue,
  input  wire logic       in_frame_last,
  output logic            out_valid,
  output logic [7:0]      out_threshold,
  output logic            out_split_found,
  output logic            out_overflow
);
  import otsu_pkg::*;

  state_t state_r, state_nxt;

  logic [BW-1:0]  gray_r, gray_nxt;
  logic           last_r, last_nxt;
  logic [NW-1:0]  total_r, total_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic           ovf_r, ovf_nxt;
  logic [BW-1:0]  k_r, k_nxt;
  logic [NW-1:0]  w_r, w_nxt;
  logic [SW-1:0]  m_r, m_nxt;
  logic           found_r, found_nxt;
  logic [BW-1:0]  best_k_r, best_k_nxt;
  logic [D2W-1:0] best_d2_r, best_d2_nxt;
  logic [QW-1:0]  best_q_r, best_q_nxt;
  logic [DW-1:0]  sw_r, sw_nxt;
  logic [DW-1:0]  d_r, d_nxt;
  logic [QW-1:0]  q_r, q_nxt;
  logic [D2W-1:0] d2_r, d2_nxt;
  logic [PW-1:0]  lhs_r, lhs_nxt;

  // shift-add multiplier
  logic [PW-1:0]  mul_a_r, mul_a_nxt;
  logic [DW-1:0]  mul_b_r, mul_b_nxt;
  logic [PW-1:0]  mul_p_r, mul_p_nxt;
  logic           mul_done;

  logic           ram_we;
  logic [BW-1:0]  ram_waddr;
  logic [NW-1:0]  ram_wdata;
  logic [BW-1:0]  ram_raddr;
  logic [NW-1:0]  ram_rdata;

  logic [BW-1:0]  gray_in;
  logic           room;
  logic           guard_ok;
  logic           k_in_range;
  logic [DW-1:0]  d_abs;
  logic           better;

  otsu_ram #(.WIDTH(NW), .DEPTH(BINS)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign gray_in    = gray_of(in_pixel_red, in_pixel_green, in_pixel_blue);
  assign room       = total_r < MAX_CNT;
  assign mul_done   = mul_b_r == '0;
  assign k_in_range = (k_r >= K_FIRST) && (k_r <= K_LAST);
  assign guard_ok   = (GUARD_K * GW'(w_r) > GW'(total_r)) &&
                      (GUARD_K * GW'(total_r - w_r) > GW'(total_r));
  assign d_abs      = (sw_r >= mul_p_r[DW-1:0]) ? sw_r - mul_p_r[DW-1:0]
                                                : mul_p_r[DW-1:0] - sw_r;
  assign better     = lhs_r > mul_p_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  state_nxt = (k_r == K_END) ? ST_IDLE : ST_CLR;
      ST_IDLE: begin
        if (start) begin
          if (room) begin
            state_nxt = ST_INC;
          end else if (in_frame_last) begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_INC:  state_nxt = last_r ? ST_RD : ST_IDLE;
      ST_RD:   state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (k_in_range && guard_ok) begin
          state_nxt = ST_SW;
        end else if (k_r == K_END) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_SW:   if (mul_done) state_nxt = ST_NM;
      ST_NM:   if (mul_done) state_nxt = (d_abs == '0) ? ST_RD : ST_Q;
      ST_Q:    if (mul_done) state_nxt = ST_DD;
      ST_DD:   if (mul_done) state_nxt = found_r ? ST_L : ST_RD;
      ST_L:    if (mul_done) state_nxt = ST_R;
      ST_R:    if (mul_done) state_nxt = ST_RD;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = state_r != ST_IDLE;
    out_valid = state_r == ST_OUT;
  end

  assign out_threshold   = best_k_r;
  assign out_split_found = found_r;
  assign out_overflow    = ovf_r;

  // datapath
  always_comb begin
    gray_nxt    = gray_r;
    last_nxt    = last_r;
    total_nxt   = total_r;
    sum_nxt     = sum_r;
    ovf_nxt     = ovf_r;
    k_nxt       = k_r;
    w_nxt       = w_r;
    m_nxt       = m_r;
    found_nxt   = found_r;
    best_k_nxt  = best_k_r;
    best_d2_nxt = best_d2_r;
    best_q_nxt  = best_q_r;
    sw_nxt      = sw_r;
    d_nxt       = d_r;
    q_nxt       = q_r;
    d2_nxt      = d2_r;
    lhs_nxt     = lhs_r;
    ram_we      = 1'b0;
    ram_waddr   = k_r;
    ram_wdata   = '0;
    ram_raddr   = k_r;

    mul_a_nxt = mul_a_r;
    mul_b_nxt = mul_b_r;
    mul_p_nxt = mul_p_r;
    if (!mul_done) begin
      if (mul_b_r[0]) begin
        mul_p_nxt = mul_p_r + mul_a_r;
      end
      mul_a_nxt = mul_a_r << 1;
      mul_b_nxt = mul_b_r >> 1;
    end

    unique case (state_r)
      ST_CLR: begin
        ram_we = 1'b1;   // zero one bin per cycle, k wraps back to 0
        k_nxt  = k_r + BW'(1);
      end
      ST_IDLE: begin
        ram_raddr = gray_in;
        if (start) begin
          gray_nxt = gray_in;
          last_nxt = in_frame_last;
          if (!room) begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_INC: begin
        ram_we    = 1'b1;
        ram_waddr = gray_r;
        ram_wdata = ram_rdata + NW'(1);
        total_nxt = total_r + NW'(1);
        sum_nxt   = sum_r + SW'(gray_r);
      end
      ST_RD: ;
      ST_ACC: begin
        w_nxt  = w_r + ram_rdata;
        m_nxt  = m_r + SW'(k_r * ram_rdata);
        ram_we = 1'b1;   // wipe the bin for the next frame
      end
      ST_EVAL: begin
        if (k_in_range && guard_ok) begin
          mul_a_nxt = PW'(sum_r);
          mul_b_nxt = DW'(w_r);
          mul_p_nxt = '0;
        end else if (k_r != K_END) begin
          k_nxt = k_r + BW'(1);
        end
      end
      ST_SW: begin
        if (mul_done) begin
          sw_nxt    = mul_p_r[DW-1:0];
          mul_a_nxt = PW'(total_r);
          mul_b_nxt = DW'(m_r);
          mul_p_nxt = '0;
        end
      end
      ST_NM: begin
        if (mul_done) begin
          d_nxt = d_abs;
          if (d_abs == '0) begin
            k_nxt = k_r + BW'(1);
          end else begin
            mul_a_nxt = PW'(w_r);
            mul_b_nxt = DW'(total_r - w_r);
            mul_p_nxt = '0;
          end
        end
      end
      ST_Q: begin
        if (mul_done) begin
          q_nxt     = mul_p_r[QW-1:0];
          mul_a_nxt = PW'(d_r);
          mul_b_nxt = d_r;
          mul_p_nxt = '0;
        end
      end
      ST_DD: begin
        if (mul_done) begin
          d2_nxt = mul_p_r[D2W-1:0];
          if (!found_r) begin
            found_nxt   = 1'b1;
            best_k_nxt  = k_r;
            best_d2_nxt = mul_p_r[D2W-1:0];
            best_q_nxt  = q_r;
            k_nxt       = k_r + BW'(1);
          end else begin
            mul_a_nxt = PW'(mul_p_r[D2W-1:0]);
            mul_b_nxt = DW'(best_q_r);
            mul_p_nxt = '0;
          end
        end
      end
      ST_L: begin
        if (mul_done) begin
          lhs_nxt   = mul_p_r;
          mul_a_nxt = PW'(best_d2_r);
          mul_b_nxt = DW'(q_r);
          mul_p_nxt = '0;
        end
      end
      ST_R: begin
        if (mul_done) begin
          if (better) begin
            best_k_nxt  = k_r;
            best_d2_nxt = d2_r;
            best_q_nxt  = q_r;
          end
          k_nxt = k_r + BW'(1);
        end
      end
      ST_OUT: begin
        total_nxt  = '0;
        sum_nxt    = '0;
        ovf_nxt    = 1'b0;
        k_nxt      = '0;
        w_nxt      = '0;
        m_nxt      = '0;
        found_nxt  = 1'b0;
        best_k_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      total_r  <= '0;
      sum_r    <= '0;
      ovf_r    <= 1'b0;
      k_r      <= '0;
      w_r      <= '0;
      m_r      <= '0;
      found_r  <= 1'b0;
      best_k_r <= '0;
      mul_b_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      sum_r    <= sum_nxt;
      ovf_r    <= ovf_nxt;
      k_r      <= k_nxt;
      w_r      <= w_nxt;
      m_r      <= m_nxt;
      found_r  <= found_nxt;
      best_k_r <= best_k_nxt;
      mul_b_r  <= mul_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gray_r    <= gray_nxt;
    last_r    <= last_nxt;
    best_d2_r <= best_d2_nxt;
    best_q_r  <= best_q_nxt;
    sw_r      <= sw_nxt;
    d_r       <= d_nxt;
    q_r       <= q_nxt;
    d2_r      <= d2_nxt;
    lhs_r     <= lhs_nxt;
    mul_a_r   <= mul_a_nxt;
    mul_p_r   <= mul_p_nxt;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/otsu_chk.sv
`default_nettype none
module otsu_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [7:0] in_pixel_red,
  input wire logic [7:0] in_pixel_green,
  input wire logic [7:0] in_pixel_blue,
  input wire logic       in_frame_last,
  input wire logic       out_valid,
  input wire logic [7:0] out_threshold,
  input wire logic       out_split_found,
  input wire logic       out_overflow
);

  // a result beat is a single cycle and frees the block
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result beat not followed by idle");

  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");

  a_no_split_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_split_found |-> out_threshold == 8'd0)
    else $error("threshold set without a split");

  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_split_found |-> out_threshold != 8'd0 && out_threshold != 8'd255)
    else $error("split outside 1..254");

endmodule

bind otsu_threshold_select_core otsu_chk u_chk (.*);
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;
  import otsu_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    bit         drain_first;
  } pixel_t;

  typedef struct {
    logic [7:0] threshold;
    logic       found;
    logic       ovf;
  } pick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] in_pixel_red = '0;
  logic [7:0] in_pixel_green = '0;
  logic [7:0] in_pixel_blue = '0;
  logic in_frame_last = 1'b0;
  logic out_valid;
  logic [7:0] out_threshold;
  logic out_split_found;
  logic out_overflow;

  pixel_t pixel_q[$];
  pick_t pick_q[$];
  longint unsigned hist[256];
  longint unsigned hist_total;
  bit hist_ovf;
  bit taken;
  int gap_left;
  int burst_left;
  int mismatches;
  int frames_seen;
  int pixels_sent;
  int found_seen;
  int idle_cycles;
  bit stim_done;

  otsu_threshold_select_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_red(in_pixel_red), .in_pixel_green(in_pixel_green),
    .in_pixel_blue(in_pixel_blue), .in_frame_last(in_frame_last),
    .out_valid(out_valid), .out_threshold(out_threshold),
    .out_split_found(out_split_found), .out_overflow(out_overflow)
  );

  always #5 clk = ~clk;

  function automatic pick_t otsu_pick();
    pick_t p;
    longint unsigned n, s, w, m, a, c, d, q, best_d, best_q;
    logic [191:0] lhs, rhs;
    bit better;
    n = 0; s = 0; w = 0; m = 0;
    best_d = 0; best_q = 1;
    p.threshold = '0;
    p.found = 1'b0;
    p.ovf = hist_ovf;
    for (int k = 0; k < 256; k++) begin
      n += hist[k];
      s += k * hist[k];
    end
    w = hist[0];
    for (int k = 1; k < 255; k++) begin
      w += hist[k];
      m += k * hist[k];
      if (1000 * w > n && 1000 * (n - w) > n) begin
        a = s * w;
        c = n * m;
        d = (a >= c) ? a - c : c - a;
        q = w * (n - w);
        if (d != 0) begin
          lhs = 192'(d) * 192'(d) * 192'(best_q);
          rhs = 192'(best_d) * 192'(best_d) * 192'(q);
          better = !p.found || (lhs > rhs);
          if (better) begin
            p.found = 1'b1;
            best_d = d;
            best_q = q;
            p.threshold = 8'(k);
          end
        end
      end
    end
    return p;
  endfunction

  task automatic clear_hist();
    foreach (hist[i]) hist[i] = 0;
    hist_total = 0;
    hist_ovf = 1'b0;
  endtask

  // histogram prediction and result check, both on the rising edge
  always @(posedge clk) begin
    logic [12:0] sum;
    pick_t want;
    if (!rst_n) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (start && !busy) begin
        pixels_sent++;
        sum = 13'(in_pixel_red) * 13'd11 + 13'(in_pixel_green) * 13'd16
            + 13'(in_pixel_blue) * 13'd5;
        if (hist_total < MAX_PIXELS) begin
          hist[sum[12:5]]++;
          hist_total++;
        end else begin
          hist_ovf = 1'b1;
        end
        if (in_frame_last) begin
          pick_q.push_back(otsu_pick());
          clear_hist();
        end
      end
      if (out_valid) begin
        if (pick_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result thr=%0d found=%0b ovf=%0b",
                     out_threshold, out_split_found, out_overflow);
        end else begin
          want = pick_q.pop_front();
          frames_seen++;
          if (want.found) found_seen++;
          if (out_threshold !== want.threshold || out_split_found !== want.found ||
              out_overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("frame %0d: exp thr=%0d found=%0b ovf=%0b, got thr=%0d found=%0b ovf=%0b",
                       frames_seen, want.threshold, want.found, want.ovf,
                       out_threshold, out_split_found, out_overflow);
          end
        end
      end
    end
  end

  // driver: bursts with random gaps, beats change on the falling edge
  always @(negedge clk) begin
    if (rst_n && (taken || !start)) begin
      if (pixel_q.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pixel_q[0].drain_first && pick_q.size() != 0) begin
        start <= 1'b0;
      end else begin
        in_pixel_red <= pixel_q[0].red;
        in_pixel_green <= pixel_q[0].green;
        in_pixel_blue <= pixel_q[0].blue;
        in_frame_last <= pixel_q[0].last;
        void'(pixel_q.pop_front());
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 500000) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic last, input bit drain = 1'b0);
    pixel_t p;
    p.red = r; p.green = g; p.blue = b; p.last = last; p.drain_first = drain;
    pixel_q.push_back(p);
  endtask

  function automatic logic [7:0] near(input int center, input int spread);
    int v;
    v = center + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic add_frame(input int len, input int kind, input bit drain);
    int c0, c1, sp, c;
    c0 = $urandom_range(0, 255);
    c1 = $urandom_range(0, 255);
    sp = $urandom_range(0, 6);
    for (int i = 0; i < len; i++) begin
      if (kind == 0) begin
        add_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()), i == len - 1,
                  drain && i == 0);
      end else begin
        c = (kind == 2 && $urandom_range(0, 1)) ? c1 : c0;
        if (kind == 2) c1 = (c0 + 10) % 256;
        add_pixel(near(c, sp), near(c, sp), near(c, sp), i == len - 1, drain && i == 0);
      end
    end
  endtask

  initial begin
    int budget;
    clear_hist();
    // directed: single pixels at the extremes, uniform frame, two clusters, ties
    add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    add_pixel(8'hff, 8'h00, 8'h00, 1'b0);
    add_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    add_pixel(8'h00, 8'h00, 8'hff, 1'b1);
    repeat (4) add_pixel(8'd100, 8'd100, 8'd100, 1'b0);
    add_pixel(8'd100, 8'd100, 8'd100, 1'b1);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b1, 1'b1);
    add_pixel(8'd10, 8'd10, 8'd10, 1'b0);
    add_pixel(8'd12, 8'd12, 8'd12, 1'b0);
    add_pixel(8'd14, 8'd14, 8'd14, 1'b1);
    add_pixel(8'h55, 8'haa, 8'h55, 1'b0);
    add_pixel(8'haa, 8'h55, 8'haa, 1'b1);
    // random frames: mostly narrow gray clusters, a few full range
    budget = 1050;
    for (int f = 0; budget > 0; f++) begin
      int len, kind;
      len = $urandom_range(1, 40);
      if (len > budget) len = budget;
      kind = (f % 12 == 5) ? 0 : $urandom_range(1, 2);
      add_frame(len, kind, f == 20);
      budget -= len;
    end
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (pixel_q.size() == 0);
    @(posedge clk);
    while (start || pick_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("%0d pixels in %0d frames checked, %0d with a split found",
             pixels_sent, frames_seen, found_seen);
    if (mismatches == 0 && pick_q.size() == 0)
      $display("Regression PASS");
    else begin
      $display("%0d mismatches, %0d results missing", mismatches, pick_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
